// ===== rtl/core/assert_macros.svh =====
// Assertion macros for the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Assert that an antecedent implies a consequent in the same cycle
`define CHK_IMPLIES(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("check failed");
// Assert that an antecedent implies a consequent in the next cycle
`define CHK_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("check failed");
`endif

// ===== rtl/core/dhvr_pkg.sv =====
// Types and constants of the dual high-voltage regulator
package dhvr_pkg;
    localparam int unsigned FULL_SCALE_VOLTS = 10830;
    localparam int unsigned KILL_LEVEL       = 50;
    localparam int unsigned TRIP_VOLTS       = 6000;
    localparam int unsigned DRAIN_VOLTS      = 80;
    localparam int unsigned DRAIN_DUTY       = 1000;
    localparam int unsigned SCHED_VOLTS      = 2000;
    localparam int unsigned ZERO_BAND_VOLTS  = 200;
    localparam int unsigned Q_OUT_SCALE      = 44741;
    localparam int unsigned Q_LO_POLE        = 47835;
    localparam int unsigned Q_LO_ZERO        = 30212;
    localparam int unsigned Q_HI_POLE        = 47795;
    localparam int unsigned Q_HI_ZERO        = 5088;

    // Drive saturation; duty fields are sized for it
    localparam int DRIVE_LIMIT = 1024;

    localparam int unsigned VOLT_W = 14;
    localparam int unsigned DUTY_W = 11;
    localparam int unsigned ERR_W  = 15;
    localparam int unsigned REG_W  = 14;

    localparam logic [1:0] REG_REF_ONE = 2'd0;
    localparam logic [1:0] REG_REF_TWO = 2'd1;
    localparam logic [1:0] REG_HALT    = 2'd2;

    // Controller to datapath
    typedef struct packed {
        logic load;      // latch the request, update lamp and trip
        logic ch_start;  // begin control of channel sel
        logic mul_step;  // advance one multiply step
        logic ch_done;   // write back channel results
        logic ch_sel;
        logic [1:0] step;
    } t_cmd;
endpackage

// ===== rtl/core/dual_hv_lag_voltage_regulator_core.sv =====
// Top level of the two-channel high-voltage lag regulator
// Sequence: RAM read after request accept, then per channel one setup, four
//   multiply steps and one write-back, then the result is offered at the output.
// Throughput: a new request is accepted only when the previous result is taken,
//   as the shared 4-bit digit output-scale multiplier serves both channels.
// Reset: synchronous active low; clears history, trip, window sums, halt=1.
module dual_hv_lag_voltage_regulator_core import dhvr_pkg::*; #(
    parameter int AVG_TAPS    = 10,
    parameter int ADC_BITS    = 12
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // kill_sample, volt_sample_one, volt_sample_two (low to high)
    input  logic [((3*ADC_BITS+7)/8)*8-1:0] s_axis_tdata,
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // charge_one, drain_one, charge_two, drain_two, avg_volt_one, avg_volt_two,
    // supply_on_lamp, trip_flag, sat_one (low to high), zero padded
    output logic [79:0] m_axis_tdata,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [REG_W-1:0] i_cfg_data
);
    t_cmd cmd;
    logic [REG_W-1:0] r_ref_one, r_ref_two;
    logic r_halt;
    logic [DUTY_W-1:0] c1, d1, c2, d2;
    logic [VOLT_W-1:0] a1, a2;
    logic lamp, trip, sat;

    // Hold configuration registers; ignore indexes past halt
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref_one <= '0;
            r_ref_two <= '0;
            r_halt    <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_REF_ONE: r_ref_one <= i_cfg_data;
                REG_REF_TWO: r_ref_two <= i_cfg_data;
                REG_HALT:    r_halt    <= i_cfg_data[0];
                default:     ;
            endcase
        end
    end

    dhvr_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(s_axis_tvalid), .o_in_ready(s_axis_tready),
        .o_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready),
        .o_cmd(cmd));

    dhvr_datapath #(.AVG_TAPS(AVG_TAPS), .ADC_BITS(ADC_BITS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd),
        .i_kill(s_axis_tdata[ADC_BITS-1:0]),
        .i_raw_one(s_axis_tdata[2*ADC_BITS-1:ADC_BITS]),
        .i_raw_two(s_axis_tdata[3*ADC_BITS-1:2*ADC_BITS]),
        .i_ref_one(r_ref_one), .i_ref_two(r_ref_two), .i_halt(r_halt),
        .o_charge_one(c1), .o_drain_one(d1), .o_charge_two(c2), .o_drain_two(d2),
        .o_avg_one(a1), .o_avg_two(a2), .o_lamp(lamp), .o_trip(trip),
        .o_sat_one(sat));

    assign m_axis_tdata = {5'd0, sat, trip, lamp, a2, a1, d2, c2, d1, c1};
endmodule

// ===== rtl/core/dhvr_ram.sv =====
// Generic single-port RAM with registered read
module dhvr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

// ===== rtl/core/dhvr_ctrl.sv =====
// Sequencer of the regulator: request handshake and step schedule
module dhvr_ctrl import dhvr_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_cmd o_cmd
);
    typedef enum logic [2:0] {
        S_IDLE, S_READ, S_START, S_MUL, S_DONE, S_OUT
    } t_state;

    t_state     r_state;
    logic       r_ch;
    logic [1:0] r_step;
    logic       r_out_valid;

    assign o_in_ready  = (r_state == S_IDLE) || (r_state == S_OUT && i_out_ready);
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd          = '0;
        o_cmd.ch_sel   = r_ch;
        o_cmd.step     = r_step;
        o_cmd.load     = o_in_ready && i_in_valid;
        o_cmd.ch_start = (r_state == S_START);
        o_cmd.mul_step = (r_state == S_MUL);
        o_cmd.ch_done  = (r_state == S_DONE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ch        <= 1'b0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE, S_OUT: begin
                    if (r_state == S_OUT && i_out_ready) begin
                        r_out_valid <= 1'b0;
                        r_state     <= S_IDLE;
                    end
                    if (o_in_ready && i_in_valid) begin
                        r_state <= S_READ;
                        r_ch    <= 1'b0;
                    end
                end
                S_READ: r_state <= S_START;
                S_START: begin
                    r_step  <= '0;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_step <= r_step + 2'd1;
                    if (r_step == 2'd3) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (r_ch) begin
                        r_state     <= S_OUT;
                        r_out_valid <= 1'b1;
                    end else begin
                        r_ch    <= 1'b1;
                        r_state <= S_START;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// ===== rtl/core/dhvr_datapath.sv =====
// Datapath: scaling, moving averages, trip and shared lag-controller multiplier
module dhvr_datapath import dhvr_pkg::*; #(
    parameter int AVG_TAPS    = 10,
    parameter int ADC_BITS    = 12
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cmd                i_cmd,
    input  logic [ADC_BITS-1:0] i_kill,
    input  logic [ADC_BITS-1:0] i_raw_one,
    input  logic [ADC_BITS-1:0] i_raw_two,
    input  logic [REG_W-1:0]    i_ref_one,
    input  logic [REG_W-1:0]    i_ref_two,
    input  logic                i_halt,
    output logic [DUTY_W-1:0]   o_charge_one,
    output logic [DUTY_W-1:0]   o_drain_one,
    output logic [DUTY_W-1:0]   o_charge_two,
    output logic [DUTY_W-1:0]   o_drain_two,
    output logic [VOLT_W-1:0]   o_avg_one,
    output logic [VOLT_W-1:0]   o_avg_two,
    output logic                o_lamp,
    output logic                o_trip,
    output logic                o_sat_one
);
    localparam int POS_W = (AVG_TAPS > 1) ? $clog2(AVG_TAPS) : 1;
    localparam int SUM_W = VOLT_W + POS_W + 1;
    localparam int DRV_W = $clog2(DRIVE_LIMIT) + 2;
    localparam int ACC_W = 48;
    localparam int PRD_W = 72;
    localparam int HALF  = AVG_TAPS / 2;
    // Reciprocal of the tap count: exact floor division for any window sum
    localparam int RCP_K = SUM_W + POS_W;
    localparam longint unsigned RCP_M = (64'd1 << RCP_K) / 64'(AVG_TAPS) + 64'd1;

    logic [POS_W-1:0]  r_pos;
    logic [VOLT_W-1:0] r_volts [2];
    logic [SUM_W-1:0]  r_sum [2];
    logic              r_lamp;
    logic              r_trip;
    logic              r_run;
    logic signed [ERR_W-1:0] r_perr [2];
    logic signed [DRV_W-1:0] r_pdrv [2];
    logic              r_wind [2];
    logic signed [ERR_W-1:0] r_err;
    logic signed [ACC_W-1:0] r_acc;
    logic signed [PRD_W-1:0] r_prod;
    logic [DUTY_W-1:0] r_charge [2];
    logic [DUTY_W-1:0] r_drain [2];
    logic [VOLT_W-1:0] r_avg [2];
    logic [VOLT_W-1:0] old_one, old_two;
    logic [VOLT_W-1:0] n_volts [2];
    logic [VOLT_W-1:0] n_avg [2];

    // Scale raw counts to volts, truncated
    always_comb begin
        n_volts[0] = VOLT_W'((32'(i_raw_one) * FULL_SCALE_VOLTS) >> ADC_BITS);
        n_volts[1] = VOLT_W'((32'(i_raw_two) * FULL_SCALE_VOLTS) >> ADC_BITS);
    end

    dhvr_ram #(.WIDTH(VOLT_W), .DEPTH(AVG_TAPS)) u_win_one (
        .i_clk(i_clk), .i_we(i_cmd.ch_start && !i_cmd.ch_sel), .i_addr(r_pos),
        .i_wdata(r_volts[0]), .o_rdata(old_one));
    dhvr_ram #(.WIDTH(VOLT_W), .DEPTH(AVG_TAPS)) u_win_two (
        .i_clk(i_clk), .i_we(i_cmd.ch_start && !i_cmd.ch_sel), .i_addr(r_pos),
        .i_wdata(r_volts[1]), .o_rdata(old_two));

    // Window RAM holds garbage after reset; a fill mark replaces unwritten taps with zero
    logic [AVG_TAPS-1:0] r_fill;

    // Channel control step values
    logic              sel;
    logic [VOLT_W-1:0] v;
    logic [REG_W-1:0]  rf;
    logic              zband;
    logic signed [ERR_W-1:0] e_use, pe_use;
    logic signed [DRV_W-1:0] pd_use;
    logic              hi;
    logic signed [ACC_W-1:0] acc_calc;
    logic signed [PRD_W-1:0] mul_b;
    logic signed [DRV_W+1:0] drv;
    logic              over;
    logic signed [DRV_W-1:0] clamp;
    logic [SUM_W-1:0]  nsum0, nsum1;

    assign sel = i_cmd.ch_sel;
    assign v   = r_volts[sel];
    assign rf  = sel ? i_ref_two : i_ref_one;
    assign hi  = v >= VOLT_W'(SCHED_VOLTS);

    always_comb begin
        zband  = (rf == '0) && (v < VOLT_W'(ZERO_BAND_VOLTS));
        e_use  = ERR_W'($signed({1'b0, rf}) - $signed({1'b0, v}));
        pe_use = r_perr[sel];
        pd_use = r_pdrv[sel];
        if (zband) begin
            e_use  = '0;
            pe_use = '0;
            pd_use = '0;
        end
        if (r_wind[sel]) begin
            e_use  = '0;
            pe_use = '0;
        end
        acc_calc = hi
            ? (ACC_W'(pd_use) * ACC_W'(Q_HI_POLE) + (ACC_W'(e_use) <<< 16)
               + ACC_W'(pe_use) * ACC_W'(Q_HI_ZERO))
            : (ACC_W'(pd_use) * ACC_W'(Q_LO_POLE) + (ACC_W'(e_use) <<< 16)
               - ACC_W'(pe_use) * ACC_W'(Q_LO_ZERO));
    end

    // Output scale multiply done by four 4-bit digits of the constant over four steps
    always_comb begin
        mul_b = PRD_W'(r_acc) * PRD_W'(signed'({1'b0,
                 4'(Q_OUT_SCALE >> (4 * (3 - 32'(i_cmd.step)))) }));
    end

    always_comb begin
        logic [PRD_W-1:0] mag;
        mag = r_prod[PRD_W-1] ? PRD_W'(-r_prod) : PRD_W'(r_prod);
        drv = (DRV_W+2)'((mag >> 32) > PRD_W'(DRIVE_LIMIT) ?
              PRD_W'(DRIVE_LIMIT + 1) : (mag >> 32));
        if (r_prod[PRD_W-1]) drv = -drv;
        over  = (drv > (DRV_W+2)'(DRIVE_LIMIT)) || (drv < -(DRV_W+2)'(DRIVE_LIMIT));
        clamp = (drv > (DRV_W+2)'(DRIVE_LIMIT)) ? DRV_W'(DRIVE_LIMIT) :
                (drv < -(DRV_W+2)'(DRIVE_LIMIT)) ? -DRV_W'(DRIVE_LIMIT) : DRV_W'(drv);
        nsum0 = r_sum[0] - (r_fill[r_pos] ? SUM_W'(old_one) : '0) + SUM_W'(r_volts[0]);
        nsum1 = r_sum[1] - (r_fill[r_pos] ? SUM_W'(old_two) : '0) + SUM_W'(r_volts[1]);
        // Rounded average from the registered sums
        n_avg[0] = VOLT_W'((64'(r_sum[0] + SUM_W'(HALF)) * RCP_M) >> RCP_K);
        n_avg[1] = VOLT_W'((64'(r_sum[1] + SUM_W'(HALF)) * RCP_M) >> RCP_K);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_fill <= '0;
            r_trip <= 1'b0;
            for (int c = 0; c < 2; c++) begin
                r_sum[c]  <= '0;
                r_perr[c] <= '0;
                r_pdrv[c] <= '0;
                r_wind[c] <= 1'b0;
            end
        end else begin
            if (i_cmd.load) begin
                r_volts <= n_volts;
                r_lamp  <= i_kill <= ADC_BITS'(KILL_LEVEL);
                if (n_volts[0] > VOLT_W'(TRIP_VOLTS) || n_volts[1] > VOLT_W'(TRIP_VOLTS))
                    r_trip <= 1'b1;
            end
            if (i_cmd.ch_start && !sel) begin
                // RAM read data valid now; fold the new sample in
                r_sum[0] <= nsum0;
                r_sum[1] <= nsum1;
                r_fill[r_pos] <= 1'b1;
                r_pos <= (32'(r_pos) + 1 >= AVG_TAPS) ? '0 : r_pos + POS_W'(1);
                r_run <= !i_halt && !r_trip;
            end
            if (i_cmd.ch_start) begin
                r_acc  <= acc_calc;
                r_err  <= e_use;
                r_prod <= '0;
            end
            if (i_cmd.mul_step) begin
                r_prod <= (r_prod <<< 4) + mul_b;
            end
            if (i_cmd.ch_done && !sel) begin
                r_avg <= n_avg;
            end
            if (i_cmd.ch_done) begin
                if (r_run) begin
                    r_wind[sel] <= over && ((r_err < 0) == (drv < 0));
                    r_perr[sel] <= r_err;
                    r_pdrv[sel] <= clamp;
                    r_charge[sel] <= (clamp > 0) ? DUTY_W'(clamp) : '0;
                    r_drain[sel]  <= (clamp > 0) ? '0 : DUTY_W'(-clamp);
                end else begin
                    r_perr[sel]   <= '0;
                    r_pdrv[sel]   <= '0;
                    r_charge[sel] <= '0;
                    r_drain[sel]  <= (v > VOLT_W'(DRAIN_VOLTS)) ? DUTY_W'(DRAIN_DUTY) : '0;
                end
            end
        end
    end

    assign o_charge_one = r_charge[0];
    assign o_drain_one  = r_drain[0];
    assign o_charge_two = r_charge[1];
    assign o_drain_two  = r_drain[1];
    assign o_avg_one    = r_avg[0];
    assign o_avg_two    = r_avg[1];
    assign o_lamp       = r_lamp;
    assign o_trip       = r_trip;
    assign o_sat_one    = r_wind[0];
endmodule

// ===== rtl/core/dhvr_checker.sv =====
// Port-level checker of the regulator core and its bind
`include "assert_macros.svh"
module dhvr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [79:0] m_axis_tdata
);
    `CHK_NEXT(a_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
    `CHK_IMPLIES(a_trip_drain, i_clk, i_rst_n, m_axis_tvalid && m_axis_tdata[73], m_axis_tdata[10:0] == 11'd0)
    `CHK_IMPLIES(a_one_side, i_clk, i_rst_n, m_axis_tvalid, m_axis_tdata[10:0] == 11'd0 || m_axis_tdata[21:11] == 11'd0)
    `CHK_NEXT(a_trip_sticky, i_clk, i_rst_n, m_axis_tvalid && m_axis_tdata[73], !m_axis_tvalid || m_axis_tdata[73])
    `CHK_IMPLIES(a_busy, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, !s_axis_tready)
endmodule

bind dual_hv_lag_voltage_regulator_core dhvr_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata));

// ===== tb/tb_top.sv =====
// Self-checking testbench for the dual high-voltage lag regulator core
`timescale 1ns / 1ps

module tb_top;
    import dhvr_pkg::*;

    localparam int TAPS  = 10;
    localparam int LIMIT = 1024;
    localparam int N_FLD = 9;
    // raw samples at or below this stay under the trip level
    localparam int RAW_SAFE = 2269;
    // register index past the last register
    localparam logic [1:0] REG_UNUSED = 2'd3;

    typedef struct {
        int unsigned fld [N_FLD];
    } t_duty_set;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [39:0]       s_axis_tdata = '0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [79:0]       m_axis_tdata;
    logic              i_cfg_we = 1'b0;
    logic [1:0]        i_cfg_index = REG_REF_ONE;
    logic [REG_W-1:0]  i_cfg_data = '0;

    dual_hv_lag_voltage_regulator_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    // Shadow copy of the regulator state and registers
    int unsigned set_ref [2];
    bit          set_halt;
    int          prior_err [2];
    int          last_drive [2];
    bit          wound [2];
    int unsigned win [2][TAPS];
    int unsigned win_sum [2];
    int unsigned win_pos;
    bit          tripped;

    t_duty_set   duty_q [$];
    int          n_bad = 0;
    int          n_checked = 0;
    int          n_sent = 0;
    bit          quiet = 1'b0;      // no idling on either side
    int          hold_cycles = 0;   // long receiver hold-off
    int          rx_burst = 0;

    string fld_name [N_FLD] = '{"charge_one", "drain_one", "charge_two", "drain_two",
        "avg_volt_one", "avg_volt_two", "supply_on_lamp", "trip_flag", "sat_one"};
    int fld_w [N_FLD] = '{11, 11, 11, 11, 14, 14, 1, 1, 1};

    function automatic int unsigned to_volts(input logic [11:0] raw);
        return (int'(raw) * FULL_SCALE_VOLTS) >> 12;
    endfunction

    // One lag controller step; returns charge and drain duties
    function automatic void lag_step(input int ch, input int unsigned v,
                                     output int unsigned chg, output int unsigned drn);
        int     err;
        longint acc;
        longint prod;
        longint mag;
        int     drv;
        bit     over;
        err = int'(set_ref[ch]) - int'(v);
        if (set_ref[ch] == 0 && v < ZERO_BAND_VOLTS) begin
            err = 0;
            prior_err[ch] = 0;
            last_drive[ch] = 0;
        end
        if (wound[ch]) begin
            err = 0;
            prior_err[ch] = 0;
        end
        if (v < SCHED_VOLTS)
            acc = longint'(Q_LO_POLE) * last_drive[ch] + longint'(err) * 65536
                - longint'(Q_LO_ZERO) * prior_err[ch];
        else
            acc = longint'(Q_HI_POLE) * last_drive[ch] + longint'(err) * 65536
                + longint'(Q_HI_ZERO) * prior_err[ch];
        prod = acc * longint'(Q_OUT_SCALE);
        // truncate toward zero
        mag = (prod < 0) ? -prod : prod;
        mag = mag >>> 32;
        drv = (prod < 0) ? -int'(mag) : int'(mag);
        over = drv > LIMIT || drv < -LIMIT;
        wound[ch] = over && ((err < 0) == (drv < 0));
        if (drv > LIMIT) drv = LIMIT;
        else if (drv < -LIMIT) drv = -LIMIT;
        if (drv > 0) begin
            chg = drv;
            drn = 0;
        end else begin
            chg = 0;
            drn = -drv;
        end
        prior_err[ch] = err;
        last_drive[ch] = drv;
    endfunction

    function automatic t_duty_set predict_duties(input logic [39:0] req);
        t_duty_set   r;
        int unsigned v [2];
        int unsigned c;
        int unsigned d;
        v[0] = to_volts(req[23:12]);
        v[1] = to_volts(req[35:24]);
        if (win_pos >= TAPS) win_pos = 0;
        for (int ch = 0; ch < 2; ch++) begin
            win_sum[ch] = win_sum[ch] - win[ch][win_pos] + v[ch];
            win[ch][win_pos] = v[ch];
            r.fld[4 + ch] = ((win_sum[ch] + TAPS / 2) / TAPS) & 14'h3FFF;
        end
        win_pos = (win_pos + 1 >= TAPS) ? 0 : win_pos + 1;
        if (v[0] > TRIP_VOLTS || v[1] > TRIP_VOLTS) tripped = 1'b1;
        for (int ch = 0; ch < 2; ch++) begin
            if (!set_halt && !tripped) begin
                lag_step(ch, v[ch], c, d);
            end else begin
                c = 0;
                d = (v[ch] > DRAIN_VOLTS) ? DRAIN_DUTY : 0;
                prior_err[ch] = 0;
                last_drive[ch] = 0;
            end
            r.fld[2 * ch] = c;
            r.fld[2 * ch + 1] = d;
        end
        r.fld[6] = (req[11:0] <= KILL_LEVEL);
        r.fld[7] = tripped;
        r.fld[8] = wound[0];
        return r;
    endfunction

    // Receiver: random stall bursts, long hold-off on request, none when quiet
    always @(posedge i_clk) begin
        if (hold_cycles > 0) begin
            m_axis_tready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end else if (rx_burst > 0) begin
            m_axis_tready <= 1'b0;
            rx_burst <= rx_burst - 1;
        end else if (!quiet && $urandom_range(0, 9) == 0) begin
            m_axis_tready <= 1'b0;
            rx_burst <= $urandom_range(0, 16);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Checker: compare each result with the oldest expectation
    always @(posedge i_clk) begin
        t_duty_set exp_r;
        int unsigned got;
        int lo;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (duty_q.size() == 0) begin
                n_bad++;
                if (n_bad <= 10) $display("ERROR: unexpected result %h", m_axis_tdata);
            end else begin
                exp_r = duty_q.pop_front();
                n_checked++;
                lo = 0;
                for (int f = 0; f < N_FLD; f++) begin
                    got = 32'((m_axis_tdata >> lo) & ((1 << fld_w[f]) - 1));
                    if (got != exp_r.fld[f]) begin
                        n_bad++;
                        if (n_bad <= 10)
                            $display("ERROR: result %0d %s expected %0d got %0d",
                                     n_checked, fld_name[f], exp_r.fld[f], got);
                    end
                    lo += fld_w[f];
                end
            end
        end
    end

    // Send one request; tvalid stays high after accept until a gap or drain_block drops it
    task automatic send_request(input logic [11:0] kill, input logic [11:0] raw1,
                                input logic [11:0] raw2);
        logic [39:0] req;
        req = {4'b0, raw2, raw1, kill};
        if (!quiet && $urandom_range(0, 7) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= req;
        do @(posedge i_clk); while (!s_axis_tready);
        duty_q.push_back(predict_duties(req));
        n_sent++;
    endtask

    // Drop valid, wait for every result, then let the pipeline settle
    task automatic drain_block();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (duty_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    // Write one register, then release the write enable before returning
    task automatic write_reg(input logic [1:0] idx, input int unsigned val);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= REG_W'(val);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        if (idx == REG_REF_ONE) set_ref[0] = val & 14'h3FFF;
        else if (idx == REG_REF_TWO) set_ref[1] = val & 14'h3FFF;
        else if (idx == REG_HALT) set_halt = 1'(val & 1);
    endtask

    // raw sample that lands near a target voltage, kept below trip
    function automatic logic [11:0] raw_near(input int unsigned volts);
        int r;
        r = int'((volts * 4096) / FULL_SCALE_VOLTS) + $urandom_range(0, 40) - 20;
        if (r < 0) r = 0;
        if (r > RAW_SAFE) r = RAW_SAFE;
        return 12'(r);
    endfunction

    function automatic logic [11:0] raw_safe();
        case ($urandom_range(0, 3))
            0: return 12'($urandom_range(0, 80));        // zero band and just above it
            1: return 12'($urandom_range(740, 780));     // around the gain switch
            default: return 12'($urandom_range(0, RAW_SAFE));
        endcase
    endfunction

    // Halted drain path, kill pin extremes, average window extremes
    task automatic test_halted_drain();
        send_request(12'd0, 12'd0, 12'd0);
        send_request(12'd50, 12'd30, 12'd31);
        send_request(12'd51, 12'd31, 12'd30);
        send_request(12'hFFF, 12'd2048, 12'd2269);
        for (int i = 0; i < 10; i++)
            send_request(12'($urandom), 12'(RAW_SAFE), 12'hFFF & 12'd2047);
        drain_block();
    endtask

    // Regulating with extreme references, zero band, windup and gain switch
    task automatic test_directed_lag();
        write_reg(REG_HALT, 0);
        write_reg(REG_REF_ONE, 0);
        write_reg(REG_REF_TWO, FULL_SCALE_VOLTS);
        send_request(12'd0, 12'd0, 12'd0);
        send_request(12'd10, 12'd75, 12'd76);
        send_request(12'd10, 12'd756, 12'd757);
        send_request(12'd10, 12'd757, 12'd756);
        send_request(12'd10, 12'd2269, 12'd0);
        send_request(12'd10, 12'd0, 12'd2269);
        drain_block();
        write_reg(REG_REF_ONE, FULL_SCALE_VOLTS);
        write_reg(REG_REF_TWO, 0);
        write_reg(REG_UNUSED, 14'h3FFF);           // unused index, ignored
        for (int i = 0; i < 5; i++) send_request(12'd60, 12'd0, 12'd2269);
        drain_block();
    endtask

    // Random regulation under several settings, mostly tracking the target
    task automatic test_random_lag(input int n_items);
        int unsigned r1;
        int unsigned r2;
        for (int seg = 0; seg < 6; seg++) begin
            r1 = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6000);
            r2 = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6000);
            write_reg(REG_REF_ONE, r1);
            write_reg(REG_REF_TWO, r2);
            write_reg(REG_HALT, (seg == 3));
            for (int i = 0; i < n_items / 6; i++) begin
                if ($urandom_range(0, 3) != 0)
                    send_request(12'($urandom), raw_near(r1), raw_near(r2));
                else
                    send_request(12'($urandom), raw_safe(), raw_safe());
            end
            drain_block();
        end
    endtask

    // Sender keeps offering while the receiver holds off for a long stretch
    task automatic test_backpressure();
        write_reg(REG_REF_ONE, 3000);
        write_reg(REG_REF_TWO, 500);
        write_reg(REG_HALT, 0);
        hold_cycles = 400;
        for (int i = 0; i < 60; i++) send_request(12'($urandom), raw_safe(), raw_safe());
        drain_block();
    endtask

    // Full input range, trips the sticky latch; no idling from here on
    task automatic test_trip_full_range(input int n_items);
        write_reg(REG_REF_ONE, $urandom_range(0, FULL_SCALE_VOLTS));
        write_reg(REG_REF_TWO, FULL_SCALE_VOLTS);
        quiet = 1'b1;
        send_request(12'd0, 12'd1000, 12'd1000);
        send_request(12'd0, 12'd2270, 12'd0);
        send_request(12'd0, 12'd0, 12'd0);
        for (int i = 0; i < n_items; i++)
            send_request(12'($urandom), 12'($urandom), 12'($urandom));
        drain_block();
    endtask

    initial begin
        set_ref = '{0, 0};
        set_halt = 1'b1;
        prior_err = '{0, 0};
        last_drive = '{0, 0};
        wound = '{0, 0};
        win = '{default: 0};
        win_sum = '{0, 0};
        win_pos = 0;
        tripped = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_halted_drain();
        test_directed_lag();
        test_random_lag(900);
        test_backpressure();
        test_trip_full_range(120);
        $display("Sent %0d requests, checked %0d results over halted, regulating,",
                 n_sent, n_checked);
        $display("back-pressure and tripped phases; %0d mismatches", n_bad);
        if (n_bad == 0 && duty_q.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial begin
        #8ms;
        $display("Timeout waiting for the regulator");
        $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== dual_hv_lag_voltage_regulator_core.f =====
+incdir+rtl/core
rtl/core/dhvr_pkg.sv
rtl/core/dhvr_ram.sv
rtl/core/dhvr_ctrl.sv
rtl/core/dhvr_datapath.sv
rtl/core/dual_hv_lag_voltage_regulator_core.sv
rtl/core/dhvr_checker.sv
tb/tb_top.sv
